// ===== sv/spk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spk_pkg
// Shared types, constants and round functions of the Speck32/64 unit.
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int unsigned MAX_ROUND_COUNT = 32;
  localparam int unsigned WORD_W          = 16;
  localparam int unsigned BLOCK_W         = 2 * WORD_W;
  localparam int unsigned KEY_W           = 4 * WORD_W;
  localparam int unsigned RC_W            = 6;
  // round and step counters hold values up to 127
  localparam int unsigned CNT_W           = 7;
  localparam int unsigned ROT_A           = 7;
  localparam int unsigned ROT_B           = 2;

  localparam logic [RC_W-1:0] RC_RESET = RC_W'(22);

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // key word rewritten by the first schedule step
  localparam logic [1:0] SLOT_FIRST = 2'd2;

  typedef struct packed {
    logic                   cmd;
    logic [WORD_W-1:0]      l;
    logic [WORD_W-1:0]      r;
    logic [2:0][WORD_W-1:0] kw;
    logic [WORD_W-1:0]      sk;      // round key of the current round
    logic [CNT_W-1:0]       cnt;     // schedule steps done
    logic [1:0]             slot;    // key word of the next forward step
    logic [CNT_W-1:0]       rounds;
  } spk_state_t;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int unsigned s);
    return (v >> s) | (v << (WORD_W - s));
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int unsigned s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  // {l, r} in, {l, r} out
  function automatic logic [BLOCK_W-1:0] fwd_round(input logic [BLOCK_W-1:0] lr,
                                                   input logic [WORD_W-1:0]  k);
    logic [WORD_W-1:0] nl;
    logic [WORD_W-1:0] nr;
    nl = (rotr(lr[BLOCK_W-1:WORD_W], ROT_A) + lr[WORD_W-1:0]) ^ k;
    nr = rotl(lr[WORD_W-1:0], ROT_B) ^ nl;
    return {nl, nr};
  endfunction

  function automatic logic [BLOCK_W-1:0] inv_round(input logic [BLOCK_W-1:0] lr,
                                                   input logic [WORD_W-1:0]  k);
    logic [WORD_W-1:0] pl;
    logic [WORD_W-1:0] pr;
    pr = rotr(lr[WORD_W-1:0] ^ lr[BLOCK_W-1:WORD_W], ROT_B);
    pl = rotl((lr[BLOCK_W-1:WORD_W] ^ k) - pr, ROT_A);
    return {pl, pr};
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [WORD_W-1:0] get_word(input logic [2:0][WORD_W-1:0] kw,
                                                 input logic [1:0]             s);
    logic [WORD_W-1:0] w;
    unique case (s)
      2'd0:    w = kw[0];
      2'd1:    w = kw[1];
      default: w = kw[2];
    endcase
    return w;
  endfunction

  function automatic logic [2:0][WORD_W-1:0] set_word(input logic [2:0][WORD_W-1:0] kw,
                                                      input logic [1:0]             s,
                                                      input logic [WORD_W-1:0]      w);
    logic [2:0][WORD_W-1:0] res;
    res = kw;
    unique case (s)
      2'd0:    res[0] = w;
      2'd1:    res[1] = w;
      default: res[2] = w;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/spk_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spk_stage
// One registered pipeline stage: either a forward key-schedule step used to
// prepare decryption, or one cipher round with its key-schedule step.
// ----------------------------------------------------------------------------
module spk_stage #(
  parameter int unsigned STAGE_IDX = 0,
  parameter bit          KEY_ONLY  = 1'b0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire spk_pkg::spk_state_t state_i,
  output logic                    valid_o,
  output spk_pkg::spk_state_t     state_o
);

  localparam logic [spk_pkg::CNT_W-1:0] STAGE    = spk_pkg::CNT_W'(STAGE_IDX);
  localparam logic [spk_pkg::CNT_W-1:0] STAGE_P1 = spk_pkg::CNT_W'(STAGE_IDX + 1);

  logic                valid_q;
  spk_pkg::spk_state_t state_d;
  spk_pkg::spk_state_t state_q;

  always_comb begin
    logic [spk_pkg::WORD_W-1:0]  w;
    logic [spk_pkg::BLOCK_W-1:0] res;
    logic [1:0]                  us;
    state_d = state_i;
    w       = spk_pkg::get_word(state_i.kw, state_i.slot);
    us      = spk_pkg::slot_inc(state_i.slot);
    res     = '0;
    if (KEY_ONLY) begin
      // decryption runs the schedule forward to its last round key first
      if (state_i.cmd == spk_pkg::CMD_DECRYPT && state_i.rounds > STAGE_P1) begin
        res           = spk_pkg::fwd_round({w, state_i.sk}, spk_pkg::WORD_W'(state_i.cnt));
        state_d.kw    = spk_pkg::set_word(state_i.kw, state_i.slot,
                                          res[spk_pkg::BLOCK_W-1:spk_pkg::WORD_W]);
        state_d.sk    = res[spk_pkg::WORD_W-1:0];
        state_d.cnt   = state_i.cnt + 1'b1;
        state_d.slot  = spk_pkg::slot_dec(state_i.slot);
      end
    end else if (state_i.rounds > STAGE) begin
      if (state_i.cmd == spk_pkg::CMD_ENCRYPT) begin
        {state_d.l, state_d.r} = spk_pkg::fwd_round({state_i.l, state_i.r}, state_i.sk);
        res          = spk_pkg::fwd_round({w, state_i.sk}, spk_pkg::WORD_W'(state_i.cnt));
        state_d.kw   = spk_pkg::set_word(state_i.kw, state_i.slot,
                                         res[spk_pkg::BLOCK_W-1:spk_pkg::WORD_W]);
        state_d.sk   = res[spk_pkg::WORD_W-1:0];
        state_d.cnt  = state_i.cnt + 1'b1;
        state_d.slot = spk_pkg::slot_dec(state_i.slot);
      end else begin
        {state_d.l, state_d.r} = spk_pkg::inv_round({state_i.l, state_i.r}, state_i.sk);
        // undo the previous schedule step to recover the next lower round key
        if (state_i.rounds > STAGE_P1) begin
          res          = spk_pkg::inv_round({spk_pkg::get_word(state_i.kw, us), state_i.sk},
                                            spk_pkg::WORD_W'(state_i.cnt - 1'b1));
          state_d.kw   = spk_pkg::set_word(state_i.kw, us,
                                           res[spk_pkg::BLOCK_W-1:spk_pkg::WORD_W]);
          state_d.sk   = res[spk_pkg::WORD_W-1:0];
          state_d.cnt  = state_i.cnt - 1'b1;
          state_d.slot = us;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule
`default_nettype wire

// ===== sv/speck32_64_block_cipher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// speck32_64_block_cipher_unit
// Speck32/64 encrypt/decrypt, fully unrolled pipeline.
//
// A block is taken on every cycle in which start is high; busy is always low.
// Each result appears on block_out_o for one cycle with result_valid_o high,
// in order, once its block has passed every pipeline register, and must be
// taken then. The latency is set by the pipeline depth: MAX_ROUND_COUNT
// key-schedule stages (used by decryption to reach the last round key)
// followed by MAX_ROUND_COUNT round stages, one register each; it does not
// depend on round_count. round_count (reset 22, clamped to MAX_ROUND_COUNT) is
// sampled per block at start and is written through the cfg channel, which
// is always ready.
// ----------------------------------------------------------------------------
module speck32_64_block_cipher_unit #(
  parameter int unsigned MAX_ROUND_COUNT = spk_pkg::MAX_ROUND_COUNT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        command_i,
  input  wire logic [spk_pkg::BLOCK_W-1:0] block_in_i,
  input  wire logic [spk_pkg::KEY_W-1:0]   cipher_key_i,
  output logic                             result_valid_o,
  output logic [spk_pkg::BLOCK_W-1:0]      block_out_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [spk_pkg::RC_W-1:0]    cfg_data_i
);

  localparam int unsigned NUM_STAGES = 2 * MAX_ROUND_COUNT;
  localparam logic [spk_pkg::CNT_W-1:0] MAX_RC = spk_pkg::CNT_W'(MAX_ROUND_COUNT);

  logic [spk_pkg::RC_W-1:0]  round_count_q;
  logic [spk_pkg::CNT_W-1:0] rounds;

  logic                stage_valid [NUM_STAGES+1];
  spk_pkg::spk_state_t stage_state [NUM_STAGES+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= spk_pkg::RC_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      round_count_q <= cfg_data_i;
    end
  end

  assign rounds = (spk_pkg::CNT_W'(round_count_q) > MAX_RC) ? MAX_RC
                                                            : spk_pkg::CNT_W'(round_count_q);

  always_comb begin
    stage_valid[0]        = start && !busy;
    stage_state[0].cmd    = command_i;
    stage_state[0].l      = block_in_i[spk_pkg::BLOCK_W-1:spk_pkg::WORD_W];
    stage_state[0].r      = block_in_i[spk_pkg::WORD_W-1:0];
    stage_state[0].kw[0]  = cipher_key_i[15:0];
    stage_state[0].kw[1]  = cipher_key_i[31:16];
    stage_state[0].kw[2]  = cipher_key_i[47:32];
    stage_state[0].sk     = cipher_key_i[63:48];
    stage_state[0].cnt    = '0;
    stage_state[0].slot   = spk_pkg::SLOT_FIRST;
    stage_state[0].rounds = rounds;
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    spk_stage #(
      .STAGE_IDX ((g < MAX_ROUND_COUNT) ? g : g - MAX_ROUND_COUNT),
      .KEY_ONLY  (g < MAX_ROUND_COUNT)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .state_i (stage_state[g]),
      .valid_o (stage_valid[g+1]),
      .state_o (stage_state[g+1])
    );
  end

  assign result_valid_o = stage_valid[NUM_STAGES];
  assign block_out_o    = {stage_state[NUM_STAGES].l, stage_state[NUM_STAGES].r};

endmodule
`default_nettype wire

// ===== sv/spk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spk_checker
// Port-level checks of the Speck32/64 unit, bound to the top level.
// ----------------------------------------------------------------------------
module spk_checker #(
  parameter int unsigned MAX_ROUND_COUNT = spk_pkg::MAX_ROUND_COUNT
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_o,
  input wire logic cfg_ready_o
);

  localparam int unsigned LATENCY = 2 * MAX_ROUND_COUNT;

  // the unit never refuses a block or a register write
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o)
    else $error("unit refused a transfer");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("accepted block produced no result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without matching start");

  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(start && !busy, LATENCY) |-> !result_valid_o)
    else $error("result strobe while pipeline empty");

endmodule

bind speck32_64_block_cipher_unit spk_checker #(
  .MAX_ROUND_COUNT (MAX_ROUND_COUNT)
) u_spk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .cfg_ready_o    (cfg_ready_o)
);
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Speck32/64 unit: a directed table with the
// published test vector and corner blocks and keys, then random blocks and
// keys over several round counts. Results are checked in order against a
// bit-accurate model of the cipher, or against a value typed into the table.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAX_RC      = spk_pkg::MAX_ROUND_COUNT;
  localparam int unsigned LATENCY     = 2 * MAX_RC;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 128;
  localparam int unsigned GAP_PCT     = 35;

  typedef enum logic {ROW_BLOCK, ROW_SET_ROUNDS} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic                        cmd;
    logic [spk_pkg::BLOCK_W-1:0] blk;
    logic [spk_pkg::KEY_W-1:0]   key;
    logic [spk_pkg::RC_W-1:0]    rounds;
    logic                        known;   // expected value typed in below
    logic [spk_pkg::BLOCK_W-1:0] known_val;
  } vector_row_t;

  // published Speck32/64 vector, key words packed k0 | l0 | l1 | l2
  localparam logic [spk_pkg::KEY_W-1:0]   TV_KEY   = 64'h0100_0908_1110_1918;
  localparam logic [spk_pkg::BLOCK_W-1:0] TV_PLAIN = 32'h6574_694c;
  localparam logic [spk_pkg::BLOCK_W-1:0] TV_CIPH  = 32'ha868_42f2;
  localparam logic [spk_pkg::KEY_W-1:0]   KEY_ONES = {spk_pkg::KEY_W{1'b1}};
  localparam logic [spk_pkg::BLOCK_W-1:0] BLK_ONES = {spk_pkg::BLOCK_W{1'b1}};

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        command = spk_pkg::CMD_ENCRYPT;
  logic [spk_pkg::BLOCK_W-1:0] block_in = '0;
  logic [spk_pkg::KEY_W-1:0]   cipher_key = '0;
  logic                        result_valid;
  logic [spk_pkg::BLOCK_W-1:0] block_out;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [spk_pkg::RC_W-1:0]    cfg_data = '0;

  logic [spk_pkg::BLOCK_W-1:0] blocks_due[$];
  vector_row_t                 vectors[$];
  logic [spk_pkg::RC_W-1:0]    round_cfg = spk_pkg::RC_RESET;
  int unsigned                 fail_count = 0;
  int unsigned                 cycle_count = 0;

  speck32_64_block_cipher_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command),
    .block_in_i     (block_in),
    .cipher_key_i   (cipher_key),
    .result_valid_o (result_valid),
    .block_out_o    (block_out),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [spk_pkg::WORD_W-1:0] rot_right(
    input logic [spk_pkg::WORD_W-1:0] v, input int unsigned s);
    return (v >> s) | (v << (spk_pkg::WORD_W - s));
  endfunction

  function automatic logic [spk_pkg::WORD_W-1:0] rot_left(
    input logic [spk_pkg::WORD_W-1:0] v, input int unsigned s);
    return (v << s) | (v >> (spk_pkg::WORD_W - s));
  endfunction

  function automatic logic [spk_pkg::BLOCK_W-1:0] speck_transform(
    input logic                        cmd,
    input logic [spk_pkg::BLOCK_W-1:0] blk,
    input logic [spk_pkg::KEY_W-1:0]   key,
    input logic [spk_pkg::RC_W-1:0]    rounds);
    logic [spk_pkg::WORD_W-1:0] words [3];
    logic [spk_pkg::WORD_W-1:0] rkeys [MAX_RC];
    logic [spk_pkg::WORD_W-1:0] sk;
    logic [spk_pkg::WORD_W-1:0] lw;
    logic [spk_pkg::WORD_W-1:0] rw;
    logic [spk_pkg::WORD_W-1:0] t;
    int unsigned                n;
    int unsigned                slot;
    int unsigned                i;
    n = (rounds > MAX_RC) ? MAX_RC : int'(rounds);
    words[0] = key[15:0];
    words[1] = key[31:16];
    words[2] = key[47:32];
    sk       = key[63:48];
    // schedule: same round on the key words, round index as key
    for (i = 0; i < n; i++) begin
      rkeys[i] = sk;
      slot = 2 - (i % 3);
      t = (rot_right(words[slot], spk_pkg::ROT_A) + sk) ^ spk_pkg::WORD_W'(i);
      sk = rot_left(sk, spk_pkg::ROT_B) ^ t;
      words[slot] = t;
    end
    lw = blk[31:16];
    rw = blk[15:0];
    if (cmd == spk_pkg::CMD_ENCRYPT) begin
      for (i = 0; i < n; i++) begin
        t = (rot_right(lw, spk_pkg::ROT_A) + rw) ^ rkeys[i];
        rw = rot_left(rw, spk_pkg::ROT_B) ^ t;
        lw = t;
      end
    end else begin
      for (i = n; i > 0; i--) begin
        t = rot_right(rw ^ lw, spk_pkg::ROT_B);
        lw = rot_left((lw ^ rkeys[i-1]) - t, spk_pkg::ROT_A);
        rw = t;
      end
    end
    return {lw, rw};
  endfunction

  task automatic add_block(input logic cmd, input logic [spk_pkg::BLOCK_W-1:0] blk,
                           input logic [spk_pkg::KEY_W-1:0] key, input logic known,
                           input logic [spk_pkg::BLOCK_W-1:0] known_val);
    vector_row_t row;
    row = '{ROW_BLOCK, cmd, blk, key, '0, known, known_val};
    vectors.push_back(row);
  endtask

  task automatic add_rounds(input logic [spk_pkg::RC_W-1:0] rounds);
    vector_row_t row;
    row = '{ROW_SET_ROUNDS, spk_pkg::CMD_ENCRYPT, '0, '0, rounds, 1'b0, '0};
    vectors.push_back(row);
  endtask

  // called right after a rising edge; start stays high for a following transfer
  task automatic send_block(input logic cmd, input logic [spk_pkg::BLOCK_W-1:0] blk,
                            input logic [spk_pkg::KEY_W-1:0] key, input logic known,
                            input logic [spk_pkg::BLOCK_W-1:0] known_val);
    start      <= 1'b1;
    command    <= cmd;
    block_in   <= blk;
    cipher_key <= key;
    do @(posedge clk_i); while (busy);
    if (known) blocks_due.push_back(known_val);
    else       blocks_due.push_back(speck_transform(cmd, blk, key, round_cfg));
  endtask

  task automatic maybe_gap(input bit enable);
    if (enable && $urandom_range(99) < GAP_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk_i);
  endtask

  // register written only with nothing in flight
  task automatic write_rounds(input logic [spk_pkg::RC_W-1:0] rounds);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= rounds;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    round_cfg = rounds;
  endtask

  function automatic logic [spk_pkg::BLOCK_W-1:0] rand_block;
    case ($urandom_range(19))
      0:       return '0;
      1:       return BLK_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [spk_pkg::KEY_W-1:0] rand_key;
    case ($urandom_range(19))
      0:       return '0;
      1:       return KEY_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result checker and watchdog
  always @(posedge clk_i) begin
    logic [spk_pkg::BLOCK_W-1:0] want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else if (rst_ni && result_valid) begin
      if (blocks_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result %h at cycle %0d", block_out, cycle_count);
      end else begin
        want = blocks_due.pop_front();
        if (block_out !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("block_out mismatch: expected %h, got %h", want, block_out);
        end
      end
    end
  end

  initial begin
    logic [spk_pkg::RC_W-1:0] phase_plan [8];
    vector_row_t              row;
    int unsigned              p;
    int unsigned              k;
    phase_plan = '{6'd22, 6'd1, 6'd31, 6'd0, 6'd32, 6'd63, 6'd2, 6'd45};

    // runs at reset value 22
    add_block(spk_pkg::CMD_ENCRYPT, TV_PLAIN, TV_KEY, 1'b0, '0);
    add_block(spk_pkg::CMD_DECRYPT, TV_CIPH, TV_KEY, 1'b0, '0);
    add_block(spk_pkg::CMD_ENCRYPT, '0, '0, 1'b0, '0);
    add_block(spk_pkg::CMD_ENCRYPT, BLK_ONES, KEY_ONES, 1'b0, '0);
    add_block(spk_pkg::CMD_DECRYPT, '0, KEY_ONES, 1'b0, '0);
    add_block(spk_pkg::CMD_DECRYPT, BLK_ONES, '0, 1'b0, '0);
    // zero rounds: identity
    add_rounds(6'd0);
    add_block(spk_pkg::CMD_ENCRYPT, 32'h1234_5678, TV_KEY, 1'b1, 32'h1234_5678);
    add_block(spk_pkg::CMD_DECRYPT, BLK_ONES, KEY_ONES, 1'b1, BLK_ONES);
    add_rounds(6'd1);
    add_block(spk_pkg::CMD_ENCRYPT, 32'h8000_0001, 64'h8000_0000_0000_0001, 1'b0, '0);
    add_block(spk_pkg::CMD_DECRYPT, 32'h0001_8000, 64'h0001_0000_8000_ffff, 1'b0, '0);
    add_rounds(6'd32);
    add_block(spk_pkg::CMD_ENCRYPT, BLK_ONES, KEY_ONES, 1'b0, '0);
    add_block(spk_pkg::CMD_DECRYPT, '0, '0, 1'b0, '0);
    // above the maximum: saturates
    add_rounds(6'd63);
    add_block(spk_pkg::CMD_ENCRYPT, TV_PLAIN, TV_KEY, 1'b0, '0);
    add_block(spk_pkg::CMD_DECRYPT, TV_CIPH, TV_KEY, 1'b0, '0);
    add_rounds(6'd33);
    add_block(spk_pkg::CMD_ENCRYPT, 32'hdead_beef, 64'h0123_4567_89ab_cdef, 1'b0, '0);
    add_rounds(spk_pkg::RC_RESET);
    add_block(spk_pkg::CMD_DECRYPT, 32'hcafe_f00d, 64'hfedc_ba98_7654_3210, 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) begin
      row = vectors[i];
      if (row.kind == ROW_SET_ROUNDS) begin
        write_rounds(row.rounds);
      end else begin
        send_block(row.cmd, row.blk, row.key, row.known, row.known_val);
        maybe_gap(1'b1);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      write_rounds((p < 8) ? phase_plan[p] : 6'($urandom_range(0, 63)));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send_block(1'($urandom), rand_block(), rand_key(), 1'b0, '0);
        // phase 2 runs back to back
        maybe_gap(p != 2);
      end
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
